// ----- hdl/strm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strm_pkg
// Types, constants and helpers shared by the sparse-table range-minimum block.
// ----------------------------------------------------------------------------
package strm_pkg;

	localparam int DEPTH     = 1024;
	localparam int LEVELS    = 11;
	localparam int VAL_W     = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = IDX_W + 1;
	localparam int LVL_W     = $clog2(LEVELS + 1);
	localparam int TBL_DEPTH = LEVELS * DEPTH;
	localparam int ADDR_W    = $clog2(TBL_DEPTH);
	localparam int SUM_W     = ((LEVELS > IDX_W) ? LEVELS : IDX_W) + 2;

	localparam logic signed [VAL_W-1:0] INT_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_BUILD = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [1:0] STATUS_RANGE     = 2'd2;
	localparam logic [1:0] STATUS_NOT_BUILT = 2'd3;

	typedef struct packed {
		logic [1:0]              mode;
		logic [IDX_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
		logic [IDX_W-1:0]        left_end;
		logic [IDX_W-1:0]        right_end;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] minimum;
		logic [1:0]              status;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUERY,
		ST_LEVEL,
		ST_READ,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic wr_elem;
		logic q_start;
		logic out_load;
		logic b_init;
		logic b_read;
		logic b_write;
		logic b_next_ent;
		logic b_next_lvl;
		logic set_ready;
	} ctrl_cmd_t;

	typedef struct packed {
		logic lvl_ok;
		logic ent_more;
		logic out_free;
	} dp_stat_t;

	// floor of log2, limited to the top level
	function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
		logic [LVL_W-1:0] k;
		k = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (x[i]) begin
				k = LVL_W'(i);
			end
		end
		if (k > LVL_W'(LEVELS - 1)) begin
			k = LVL_W'(LEVELS - 1);
		end
		return k;
	endfunction

	function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
		input logic [IDX_W-1:0] idx);
		return ADDR_W'({lvl, idx});
	endfunction

endpackage
`default_nettype wire

// ----- hdl/strm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module strm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output      logic [WIDTH-1:0]  rdata_a,
	output      logic [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/strm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strm_ctrl
// Controller: sequences writes, queries and the level-by-level table build.
// ----------------------------------------------------------------------------
module strm_ctrl
	import strm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_mode,
	output      logic       in_ready,
	input  wire dp_stat_t   stat,
	output      ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_mode)
						MODE_QUERY: state_d = ST_QUERY;
						MODE_BUILD: state_d = ST_LEVEL;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_QUERY: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_LEVEL: begin
				state_d = stat.lvl_ok ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				state_d = stat.ent_more ? ST_READ : ST_LEVEL;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.wr_elem = (in_mode == MODE_WRITE);
					cmd.q_start = (in_mode == MODE_QUERY);
					cmd.b_init  = (in_mode == MODE_BUILD);
				end
			end
			ST_QUERY: begin
				cmd.out_load = stat.out_free;
			end
			ST_LEVEL: begin
				cmd.set_ready = !stat.lvl_ok;
			end
			ST_READ: begin
				cmd.b_read = 1'b1;
			end
			ST_WRITE: begin
				cmd.b_write    = 1'b1;
				cmd.b_next_ent = stat.ent_more;
				cmd.b_next_lvl = !stat.ent_more;
			end
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/strm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strm_dp
// Datapath: level table, build counters, query addressing and output register.
// ----------------------------------------------------------------------------
module strm_dp
	import strm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire in_item_t         in_data,
	input  wire logic             cfg_wr_en,
	input  wire logic [CNT_W-1:0] cfg_wr_data,
	input  wire ctrl_cmd_t        cmd,
	output      dp_stat_t         stat,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      out_item_t        out_data
);

	logic [CNT_W-1:0] cnt_q;
	logic             ready_q;
	logic [CNT_W-1:0] n_act;

	logic [LVL_W-1:0] lvl_q;
	logic [IDX_W-1:0] ent_q;
	logic [SUM_W-1:0] run_len;
	logic [SUM_W-1:0] n_ext;

	logic [CNT_W-1:0] q_len;
	logic [LVL_W-1:0] q_k;
	logic [CNT_W-1:0] q_dist;
	logic [IDX_W-1:0] q_bidx;
	logic [1:0]       q_status;
	logic [1:0]       status_q;

	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [VAL_W-1:0]        ram_wdata;
	logic                    ram_re;
	logic [ADDR_W-1:0]       ram_raddr_a;
	logic [ADDR_W-1:0]       ram_raddr_b;
	logic [VAL_W-1:0]        rd_a;
	logic [VAL_W-1:0]        rd_b;
	logic signed [VAL_W-1:0] rd_min;

	logic      out_valid_q;
	out_item_t out_data_q;

	// element count and ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= CNT_W'(DEPTH);
			ready_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cnt_q <= cfg_wr_data;
			end
			if (cfg_wr_en || cmd.wr_elem) begin
				ready_q <= 1'b0;
			end else if (cmd.set_ready) begin
				ready_q <= 1'b1;
			end
		end
	end

	always_comb begin
		if (cnt_q == '0) begin
			n_act = CNT_W'(1);
		end else if (cnt_q > CNT_W'(DEPTH)) begin
			n_act = CNT_W'(DEPTH);
		end else begin
			n_act = cnt_q;
		end
	end

	// build counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
			ent_q <= '0;
		end else begin
			if (cmd.b_init) begin
				lvl_q <= LVL_W'(1);
				ent_q <= '0;
			end else if (cmd.b_next_lvl) begin
				lvl_q <= lvl_q + LVL_W'(1);
				ent_q <= '0;
			end else if (cmd.b_next_ent) begin
				ent_q <= ent_q + IDX_W'(1);
			end
		end
	end

	assign run_len = SUM_W'(1) << (lvl_q - LVL_W'(1));
	assign n_ext   = SUM_W'(n_act);

	assign stat.lvl_ok   = (lvl_q < LVL_W'(LEVELS)) && ((run_len << 1) <= n_ext);
	assign stat.ent_more = (SUM_W'(ent_q) + SUM_W'(1) + (run_len << 1)) <= n_ext;

	// query addressing and status
	always_comb begin
		q_len  = {1'b0, in_data.right_end} - {1'b0, in_data.left_end} + CNT_W'(1);
		q_k    = floor_log2(q_len);
		q_dist = CNT_W'(1) << q_k;
		q_bidx = IDX_W'({1'b0, in_data.right_end} + CNT_W'(1) - q_dist);
		if (!ready_q) begin
			q_status = STATUS_NOT_BUILT;
		end else if (in_data.left_end > in_data.right_end) begin
			q_status = STATUS_EMPTY;
		end else if ({1'b0, in_data.right_end} >= n_act) begin
			q_status = STATUS_RANGE;
		end else begin
			q_status = STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			status_q <= q_status;
		end
	end

	// table memory ports
	always_comb begin
		ram_we    = cmd.wr_elem || cmd.b_write;
		ram_waddr = cmd.wr_elem ? tbl_addr('0, in_data.position) : tbl_addr(lvl_q, ent_q);
		ram_wdata = cmd.wr_elem ? in_data.value : rd_min;
		ram_re    = cmd.q_start || cmd.b_read;
		if (cmd.q_start) begin
			ram_raddr_a = tbl_addr(q_k, in_data.left_end);
			ram_raddr_b = tbl_addr(q_k, q_bidx);
		end else begin
			ram_raddr_a = tbl_addr(lvl_q - LVL_W'(1), ent_q);
			ram_raddr_b = tbl_addr(lvl_q - LVL_W'(1), ent_q + run_len[IDX_W-1:0]);
		end
	end

	strm_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TBL_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	assign rd_min = ($signed(rd_a) < $signed(rd_b)) ? $signed(rd_a) : $signed(rd_b);

	// output register
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q.status <= status_q;
			case (status_q)
				STATUS_OK:    out_data_q.minimum <= rd_min;
				STATUS_EMPTY: out_data_q.minimum <= INT_MAX;
				default:      out_data_q.minimum <= '0;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

// ----- hdl/sparse_table_range_min.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_table_range_min
// Range-minimum engine on signed 32-bit values over a sparse level table.
// ----------------------------------------------------------------------------
// Input beats carry a mode: write element, build table or range query.
// Only a query beat yields an output beat (minimum and status).
// A write beat stores the value into level 0.
// A query beat issues both table reads on the accept edge; the output
// register loads from ST_QUERY once it is free, and no new beat is taken
// until then.
// A build beat walks each level p entry by entry (read, then write)
// through the single write port, covering n + 1 - 2^p entries on
// level p.
// The user writes element_count via cfg_wr_en / cfg_wr_data only while idle
// (not enforced); such a write or an element write clears the built flag.
// Reset clears the control state and the built flag; the table contents are
// undefined until written and need no clearing pass.
// When the receiver stalls, the result waits in the output register; a
// finished query then holds in the controller until the register frees.
// ----------------------------------------------------------------------------
module sparse_table_range_min
	import strm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_ready,
	input  wire in_item_t         in_data,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      out_item_t        out_data,
	input  wire logic             cfg_wr_en,
	input  wire logic [CNT_W-1:0] cfg_wr_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	strm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_mode  (in_data.mode),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	strm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule
`default_nettype wire

// ----- tb/sv/sparse_table_range_min_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_table_range_min_test
// Self-checking bench for the sparse-table range-minimum block. A queue of
// write, build and query beats feeds a valid/ready driver. A shadow copy of
// the level table predicts every query answer, and a monitor compares each
// output beat field by field. The element count is changed between phases
// while the block is idle, and the phases cycle through four idle patterns.
// ----------------------------------------------------------------------------
module sparse_table_range_min_test;
	import strm_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	// builds at full depth dominate the run time
	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned REPORT_CAP = 200;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} pace_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_item_t         in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_item_t        out_data;
	logic             cfg_wr_en = 1'b0;
	logic [CNT_W-1:0] cfg_wr_data = '0;

	sparse_table_range_min i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// shadow of the block state
	logic signed [VAL_W-1:0] shadow_tbl [LEVELS][DEPTH];
	logic                    shadow_built = 1'b0;
	logic [CNT_W-1:0]        shadow_count = CNT_W'(DEPTH);
	out_item_t               answers_due [$];
	out_item_t               want_answer;

	// stimulus side
	in_item_t    beat_queue [$];
	bit          loaded [DEPTH];
	pace_t       pace = IDLE_NONE;
	int unsigned beats_queued = 0;
	int unsigned beats_taken = 0;
	int unsigned builds_seen = 0;
	int unsigned answers_seen = 0;
	int unsigned mismatches = 0;
	int unsigned cycles_run = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles_run <= cycles_run + 1;
	end

	initial begin
		wait (cycles_run >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d answers outstanding", cycles_run,
			answers_due.size());
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int unsigned live_count(input logic [CNT_W-1:0] word);
		if (word == '0) begin
			return 1;
		end
		if (word > CNT_W'(DEPTH)) begin
			return DEPTH;
		end
		return int'(word);
	endfunction

	function automatic logic signed [VAL_W-1:0] smaller(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	// update the shadow table for one accepted beat, queue the answer of a query
	task automatic apply_beat(input in_item_t b);
		int unsigned n;
		int unsigned k;
		int unsigned d;
		int unsigned span;
		out_item_t   ans;
		n = live_count(shadow_count);
		case (b.mode)
			MODE_WRITE: begin
				shadow_tbl[0][b.position] = b.value;
				shadow_built = 1'b0;
			end
			MODE_BUILD: begin
				d = 1;
				for (int p = 1; p < LEVELS && 2 * d <= n; p++) begin
					for (int i = 0; i + 2 * d <= n; i++) begin
						shadow_tbl[p][i] = smaller(shadow_tbl[p-1][i], shadow_tbl[p-1][i+d]);
					end
					d = d * 2;
				end
				shadow_built = 1'b1;
				builds_seen++;
			end
			MODE_QUERY: begin
				ans.minimum = '0;
				ans.status = STATUS_OK;
				if (!shadow_built) begin
					ans.status = STATUS_NOT_BUILT;
				end else if (b.left_end > b.right_end) begin
					ans.minimum = INT_MAX;
					ans.status = STATUS_EMPTY;
				end else if (b.right_end >= n) begin
					ans.status = STATUS_RANGE;
				end else begin
					span = b.right_end - b.left_end + 1;
					k = 0;
					while (span > 1) begin
						span = span >> 1;
						k++;
					end
					if (k > LEVELS - 1) begin
						k = LEVELS - 1;
					end
					d = 1 << k;
					ans.minimum = smaller(shadow_tbl[k][b.left_end],
						shadow_tbl[k][b.right_end + 1 - d]);
				end
				answers_due = {answers_due, ans};
			end
			default: begin
			end
		endcase
	endtask

	function automatic bit send_gap();
		return (pace == IDLE_SEND && $urandom_range(99) < 70) ||
			(pace == IDLE_BOTH && $urandom_range(99) < 25);
	endfunction

	function automatic bit recv_stall();
		return (pace == IDLE_RECV && $urandom_range(99) < 70) ||
			(pace == IDLE_BOTH && $urandom_range(99) < 25);
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				apply_beat(in_data);
				beats_taken++;
			end
			if (!in_valid || in_ready) begin
				if (beat_queue.size() != 0 && !send_gap()) begin
					in_data <= beat_queue.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_CAP) begin
						$error("result beat with nothing outstanding: minimum %0d status %0d",
							out_data.minimum, out_data.status);
					end
				end else begin
					want_answer = answers_due.pop_front();
					answers_seen++;
					if (out_data.minimum !== want_answer.minimum) begin
						mismatches++;
						if (mismatches <= REPORT_CAP) begin
							$error("minimum: expected %0d, got %0d", want_answer.minimum,
								out_data.minimum);
						end
					end
					if (out_data.status !== want_answer.status) begin
						mismatches++;
						if (mismatches <= REPORT_CAP) begin
							$error("status: expected %0d, got %0d", want_answer.status,
								out_data.status);
						end
					end
				end
			end
			out_ready <= !recv_stall();
		end
	end

	function automatic logic signed [VAL_W-1:0] pick_value();
		logic signed [VAL_W-1:0] v;
		case ($urandom_range(11))
			0: v = INT_MAX;
			1: v = {1'b1, {(VAL_W-1){1'b0}}};
			2: v = '0;
			3: v = '1;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// unused fields carry random bits
	function automatic in_item_t junk_item(input logic [1:0] mode);
		in_item_t b;
		b = {$urandom, $urandom};
		b.mode = mode;
		return b;
	endfunction

	task automatic send_write(input int unsigned pos, input logic signed [VAL_W-1:0] val);
		in_item_t b;
		b = junk_item(MODE_WRITE);
		b.position = IDX_W'(pos);
		b.value = val;
		loaded[pos] = 1'b1;
		beat_queue = {beat_queue, b};
		beats_queued++;
	endtask

	task automatic send_build();
		beat_queue = {beat_queue, junk_item(MODE_BUILD)};
		beats_queued++;
	endtask

	task automatic send_query(input int unsigned l, input int unsigned r);
		in_item_t b;
		b = junk_item(MODE_QUERY);
		b.left_end = IDX_W'(l);
		b.right_end = IDX_W'(r);
		beat_queue = {beat_queue, b};
		beats_queued++;
	endtask

	task automatic send_unused();
		beat_queue = {beat_queue, junk_item(MODE_UNUSED)};
	endtask

	task automatic send_good_query(input int unsigned n);
		int unsigned l;
		int unsigned r;
		r = $urandom_range(n - 1);
		case ($urandom_range(3))
			0: l = r;
			1: begin
				l = 0;
				r = n - 1;
			end
			default: l = $urandom_range(r);
		endcase
		send_query(l, r);
	endtask

	// writes, a build, then a burst of queries; now and then a broken variant
	task automatic run_round(input int unsigned n);
		int unsigned twist;
		int unsigned r;
		twist = $urandom_range(9);
		repeat ($urandom_range(6)) begin
			if ($urandom_range(9) == 0) begin
				send_write($urandom_range(DEPTH - 1), pick_value());
			end else begin
				send_write($urandom_range(n - 1), pick_value());
			end
		end
		for (int i = 0; i < n; i++) begin
			if (!loaded[i]) begin
				send_write(i, pick_value());
			end
		end
		if (twist == 0) begin
			send_query($urandom_range(DEPTH - 1), $urandom_range(DEPTH - 1));
		end
		if (twist == 1) begin
			send_unused();
		end
		send_build();
		repeat ((n >= 512) ? $urandom_range(30, 10) : $urandom_range(12, 3)) begin
			case ($urandom_range(9))
				0: begin
					r = $urandom_range(DEPTH - 2);
					send_query($urandom_range(DEPTH - 1, r + 1), r);
				end
				1: send_query($urandom_range(DEPTH - 1), $urandom_range(DEPTH - 1));
				2: begin
					if (n < DEPTH) begin
						r = $urandom_range(DEPTH - 1, n);
						send_query($urandom_range(r), r);
					end else begin
						send_good_query(n);
					end
				end
				default: send_good_query(n);
			endcase
		end
		if (twist == 2) begin
			send_write($urandom_range(n - 1), pick_value());
			send_query(0, n - 1);
		end
	endtask

	task automatic write_count(input logic [CNT_W-1:0] word);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= word;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_count = word;
		shadow_built = 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (beat_queue.size() != 0 || in_valid || answers_due.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		logic [CNT_W-1:0] word;
		int unsigned      n;
		int unsigned      start;
		int unsigned      budget;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// no build yet at the reset count
		send_query(0, DEPTH - 1);
		send_query(DEPTH - 1, 0);
		wait_drained();

		// count of zero behaves as one element
		write_count('0);
		send_query(0, 0);
		send_write(0, {1'b1, {(VAL_W-1){1'b0}}});
		send_write(DEPTH - 1, INT_MAX);
		send_build();
		send_query(0, 0);
		send_query(1, 0);
		send_query(0, 1);
		send_query(DEPTH - 1, DEPTH - 1);
		send_query(DEPTH - 1, 0);
		send_unused();
		send_write(0, INT_MAX);
		send_query(0, 0);
		send_build();
		send_query(0, 0);
		wait_drained();

		write_count(CNT_W'(2));
		send_write(1, '1);
		send_write(0, '0);
		send_build();
		send_query(0, 1);
		send_query(1, 1);
		send_query(0, 0);
		send_query(0, 2);

		for (int ph = 0; ph < 12; ph++) begin
			wait_drained();
			case (ph)
				1: word = '1;
				3: word = CNT_W'(1);
				4: word = CNT_W'(2);
				6: word = CNT_W'(DEPTH);
				9: word = '0;
				default: word = CNT_W'($urandom_range(64, 3));
			endcase
			budget = (ph == 1) ? 1020 : ((ph == 6) ? 120 : 70);
			pace = pace_t'(ph % 4);
			write_count(word);
			n = live_count(word);
			start = beats_queued;
			while (beats_queued - start < budget) begin
				run_round(n);
			end
		end

		wait_drained();
		repeat (32) @(negedge clk);
		$display("covered %0d input beats with %0d table builds over 14 element counts",
			beats_taken, builds_seen);
		$display("checked %0d query answers under four idle patterns", answers_seen);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
